@@ src/cptpi_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the cubic point-to-point interpolator.
// No dependencies.
package cptpi_pkg;

	localparam int TIME_BITS_DEF     = 32;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int IN_W      = 32;
	localparam int POS_W     = 32;
	localparam int BLEND_W   = 17;
	localparam int BLEND_LSB = 3 * POS_W;
	localparam int OUT_W     = 120;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	localparam logic [BLEND_W-1:0] Q16_ONE = 17'h10000;

	typedef enum logic [1:0] {
		MODE_BEFORE,
		MODE_RUN,
		MODE_DONE
	} mode_t;

	typedef enum logic [2:0] {
		REG_START_TIME,
		REG_MOVE_DURATION,
		REG_START_X,
		REG_START_Y,
		REG_START_Z,
		REG_TARGET_X,
		REG_TARGET_Y,
		REG_TARGET_Z
	} reg_idx_t;

endpackage

@@ src/cubic_point_to_point_interpolator.sv @@
`timescale 1ns / 1ps
// Rest-to-rest cubic trajectory interpolator, x/y/z plus Q16 blend fraction.
// Depends on cptpi_pkg.

// Each input item is a tick count; each result gives the cubic position on
// x, y and z between the configured start and target points, and the blend
// fraction s = u^2(3-2u) in Q16 (65536 when the move is done). Before
// start_time the start point comes out; at or after start_time plus
// move_duration (including a zero duration) the target. One item is taken
// per clock while the output is not stalled, through a pipeline whose restoring
// divider makes one quotient bit per stage. Registers must be written through
// the APB port only while no item is in flight; the block does not enforce this.
module cubic_point_to_point_interpolator
	import cptpi_pkg::*;
#(
	parameter int TIME_BITS     = TIME_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // [31:0] now_ticks
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z,
	                                     // [112:96] blend_fraction, rest zero
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int TW = (TIME_BITS < 32) ? TIME_BITS : 32;
	localparam int FB = FRACTION_BITS;
	localparam int N  = FB + 5;
	localparam int PW = 34 + FB;
	localparam logic [FB+1:0] THREE_ONE = (FB+2)'(3) << FB;

	// configuration registers
	logic [31:0] start_time_q;
	logic [31:0] duration_q;
	logic [31:0] start_q [3];
	logic [31:0] target_q [3];
	logic        wr_en;
	reg_idx_t    wr_idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign wr_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q <= '0;
			duration_q   <= 32'd1;
			for (int i = 0; i < 3; i++) begin
				start_q[i]  <= '0;
				target_q[i] <= '0;
			end
		end else if (wr_en) begin
			case (wr_idx)
				REG_START_TIME:    start_time_q <= pwdata;
				REG_MOVE_DURATION: duration_q   <= pwdata;
				REG_START_X:       start_q[0]   <= pwdata;
				REG_START_Y:       start_q[1]   <= pwdata;
				REG_START_Z:       start_q[2]   <= pwdata;
				REG_TARGET_X:      target_q[0]  <= pwdata;
				REG_TARGET_Y:      target_q[1]  <= pwdata;
				REG_TARGET_Z:      target_q[2]  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (wr_idx)
			REG_START_TIME:    prdata = start_time_q;
			REG_MOVE_DURATION: prdata = duration_q;
			REG_START_X:       prdata = start_q[0];
			REG_START_Y:       prdata = start_q[1];
			REG_START_Z:       prdata = start_q[2];
			REG_TARGET_X:      prdata = target_q[0];
			REG_TARGET_Y:      prdata = target_q[1];
			REG_TARGET_Z:      prdata = target_q[2];
			default:           prdata = '0;
		endcase
	end

	// pipeline flow control: a stage loads when empty or when its successor moves
	logic [N-1:0] vld_q;
	logic [N-1:0] en;

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_flow
			if (k == N - 1) begin : g_last
				assign en[k] = !vld_q[k] || m_tready;
			end else begin : g_mid
				assign en[k] = !vld_q[k] || en[k+1];
			end
			if (k == 0) begin : g_first
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n)
						vld_q[k] <= 1'b0;
					else if (en[k])
						vld_q[k] <= s_tvalid;
				end
			end else begin : g_next
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n)
						vld_q[k] <= 1'b0;
					else if (en[k])
						vld_q[k] <= vld_q[k-1];
				end
			end
		end
	endgenerate

	assign s_tready = en[0];
	assign m_tvalid = vld_q[N-1];

	// stage 1: elapsed time and segment
	logic [TW-1:0] now_m, st_m, dur_m, elapsed;
	mode_t         mode_in;
	logic [TW-1:0] elapsed_s1;
	mode_t         mode_s1;

	always_comb begin
		now_m   = s_tdata[TW-1:0];
		st_m    = start_time_q[TW-1:0];
		dur_m   = duration_q[TW-1:0];
		elapsed = now_m - st_m;
		if (now_m < st_m)
			mode_in = MODE_BEFORE;
		else if (elapsed >= dur_m)
			mode_in = MODE_DONE;
		else
			mode_in = MODE_RUN;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			elapsed_s1 <= elapsed;
			mode_s1    <= mode_in;
		end
	end

	// divider stages: u = elapsed * 2^F / duration, one quotient bit each
	logic [TW-1:0] rem_sdiv  [FB];
	logic [FB-1:0] quo_sdiv  [FB];
	mode_t         mode_sdiv [FB];

	genvar d;
	generate
		for (d = 0; d < FB; d++) begin : g_div
			logic [TW-1:0] rem_in;
			logic [FB-1:0] quo_in;
			mode_t         md_in;
			logic [TW:0]   dbl, sub;
			logic          ge;

			if (d == 0) begin : g_head
				assign rem_in = elapsed_s1;
				assign quo_in = '0;
				assign md_in  = mode_s1;
			end else begin : g_body
				assign rem_in = rem_sdiv[d-1];
				assign quo_in = quo_sdiv[d-1];
				assign md_in  = mode_sdiv[d-1];
			end

			assign dbl = {rem_in, 1'b0};
			assign ge  = dbl >= {1'b0, dur_m};
			assign sub = dbl - {1'b0, dur_m};

			always_ff @(posedge clk) begin
				if (en[d+1]) begin
					rem_sdiv[d]  <= ge ? sub[TW-1:0] : dbl[TW-1:0];
					quo_sdiv[d]  <= {quo_in[FB-2:0], ge};
					mode_sdiv[d] <= md_in;
				end
			end
		end
	endgenerate

	// stage 2: u^2
	logic [2*FB-1:0] uu;
	logic [FB-1:0]   u_s2, u2_s2;
	mode_t           mode_s2;

	assign uu = quo_sdiv[FB-1] * quo_sdiv[FB-1];

	always_ff @(posedge clk) begin
		if (en[FB+1]) begin
			u_s2    <= quo_sdiv[FB-1];
			u2_s2   <= uu[2*FB-1:FB];
			mode_s2 <= mode_sdiv[FB-1];
		end
	end

	// stage 3: s = u^2 (3 - 2u)
	logic [FB+1:0]   factor;
	logic [2*FB+1:0] blend_prod;
	logic [FB-1:0]   s_s3;
	mode_t           mode_s3;

	assign factor     = THREE_ONE - {1'b0, u_s2, 1'b0};
	assign blend_prod = (2*FB+2)'(u2_s2) * (2*FB+2)'(factor);

	always_ff @(posedge clk) begin
		if (en[FB+2]) begin
			s_s3    <= blend_prod[2*FB-1:FB];
			mode_s3 <= mode_s2;
		end
	end

	// stage 4: (target - start) * s per axis
	logic signed [PW-1:0] prod_s4 [3];
	logic [FB-1:0]        s_s4;
	mode_t                mode_s4;
	logic signed [FB:0]   s_signed;

	assign s_signed = $signed({1'b0, s_s3});

	// stage 5: position select and output register
	logic [POS_W-1:0]   pos_s5 [3];
	logic [BLEND_W-1:0] blend_s5;
	logic [BLEND_W-1:0] blend_run;

	genvar a;
	generate
		for (a = 0; a < 3; a++) begin : g_axis
			logic signed [32:0]   delta;
			logic signed [PW-1:0] mul;
			logic [POS_W-1:0]     pos_run;

			assign delta   = $signed({target_q[a][31], target_q[a]})
			               - $signed({start_q[a][31], start_q[a]});
			assign mul     = delta * s_signed;
			assign pos_run = start_q[a] + prod_s4[a][FB+31:FB];

			always_ff @(posedge clk) begin
				if (en[FB+3])
					prod_s4[a] <= mul;
			end

			always_ff @(posedge clk) begin
				if (en[FB+4]) begin
					case (mode_s4)
						MODE_BEFORE: pos_s5[a] <= start_q[a];
						MODE_DONE:   pos_s5[a] <= target_q[a];
						default:     pos_s5[a] <= pos_run;
					endcase
				end
			end
		end

		if (FB >= 16) begin : g_q16_down
			assign blend_run = {1'b0, s_s4[FB-1:FB-16]};
		end else begin : g_q16_up
			assign blend_run = {1'b0, s_s4, (16-FB)'(0)};
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en[FB+3]) begin
			s_s4    <= s_s3;
			mode_s4 <= mode_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en[FB+4]) begin
			case (mode_s4)
				MODE_BEFORE: blend_s5 <= '0;
				MODE_DONE:   blend_s5 <= Q16_ONE;
				default:     blend_s5 <= blend_run;
			endcase
		end
	end

	assign m_tdata = {(OUT_W - BLEND_LSB - BLEND_W)'(0), blend_s5,
	                  pos_s5[2], pos_s5[1], pos_s5[0]};

endmodule

@@ src/cptpi_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the cubic point-to-point interpolator, bound to the top.
// Depends on cptpi_pkg and cubic_point_to_point_interpolator.
module cptpi_checker
	import cptpi_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_W-1:0]  m_tdata,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	input logic [DATA_W-1:0] prdata,
	input logic              pready
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an empty output stage never blocks the input
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	// blend never exceeds one
	a_blend_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[BLEND_LSB +: BLEND_W] <= Q16_ONE)
		else $error("blend fraction above one");

	// register reads back what was just written
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready) ##1
		(psel && !pwrite && paddr == $past(paddr)) |-> prdata == $past(pwdata))
		else $error("register readback mismatch");

endmodule

bind cubic_point_to_point_interpolator cptpi_checker u_cptpi_checker (.*);

@@ test/trajectory_checker.sv @@
`timescale 1ns / 1ps
// Checker for the cubic point-to-point interpolator: shadows the registers from APB writes,
// predicts the position and blend of each time sample and compares the output stream.
// Depends on cptpi_pkg.
module trajectory_checker
	import cptpi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // [31:0] now_ticks
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [OUT_W-1:0]  m_tdata,   // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z,
	                                     // [112:96] blend_fraction, rest zero
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              pready,
	output int                mismatches,
	output int                outstanding,
	output int                points_checked
);

	localparam int FRAC     = FRACTION_BITS_DEF;
	localparam int NUM_REGS = 8;
	localparam int PAD_LSB  = BLEND_LSB + BLEND_W;

	typedef struct {
		logic [POS_W-1:0]   pos [3];
		logic [BLEND_W-1:0] blend;
	} point_t;

	logic [DATA_W-1:0] regfile [NUM_REGS];
	point_t            expected_points [$];
	int                error_count = 0;
	int                checked = 0;
	int                queued = 0;

	assign mismatches     = error_count;
	assign outstanding    = queued;
	assign points_checked = checked;

	function automatic point_t cubic_point(input logic [IN_W-1:0] now);
		point_t            pt;
		mode_t             mode;
		longint unsigned   start, dur, elapsed, u, u2, s;
		longint            a, b, p;
		start   = regfile[REG_START_TIME];
		dur     = regfile[REG_MOVE_DURATION];
		elapsed = 0;
		s       = 0;
		if (now < start) begin
			mode = MODE_BEFORE;
		end else begin
			elapsed = now - start;
			mode = (elapsed >= dur) ? MODE_DONE : MODE_RUN;
		end
		if (mode == MODE_RUN) begin
			u  = (elapsed << FRAC) / dur;
			u2 = (u * u) >> FRAC;
			s  = (u2 * ((3 << FRAC) - 2 * u)) >> FRAC;
		end
		for (int ax = 0; ax < 3; ax++) begin
			a = longint'(signed'(regfile[REG_START_X + ax]));
			b = longint'(signed'(regfile[REG_TARGET_X + ax]));
			case (mode)
				MODE_BEFORE: p = a;
				MODE_DONE:   p = b;
				default:     p = a + (((b - a) * longint'(s)) >>> FRAC);
			endcase
			pt.pos[ax] = p[POS_W-1:0];
		end
		case (mode)
			MODE_BEFORE: pt.blend = '0;
			MODE_DONE:   pt.blend = Q16_ONE;
			default: begin
				if (FRAC >= 16)
					pt.blend = BLEND_W'(s >> (FRAC - 16));
				else
					pt.blend = BLEND_W'(s << (16 - FRAC));
			end
		endcase
		return pt;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%t trajectory_checker: %s", $time, what);
		error_count++;
	endtask

	task automatic check_point(input logic [OUT_W-1:0] data);
		point_t             want;
		logic [POS_W-1:0]   got_pos;
		logic [BLEND_W-1:0] got_blend;
		string              axes;
		axes = "xyz";
		if (expected_points.size() == 0) begin
			report_mismatch($sformatf("result with nothing expected, data %h", data));
		end else begin
			want = expected_points.pop_front();
			checked++;
			for (int ax = 0; ax < 3; ax++) begin
				got_pos = data[ax*POS_W +: POS_W];
				if (got_pos !== want.pos[ax])
					report_mismatch($sformatf("pos_%c got %0d want %0d", axes[ax],
						signed'(got_pos), signed'(want.pos[ax])));
			end
			got_blend = data[BLEND_LSB +: BLEND_W];
			if (got_blend !== want.blend)
				report_mismatch($sformatf("blend_fraction got %0d want %0d",
					got_blend, want.blend));
			if (data[OUT_W-1:PAD_LSB] !== '0)
				report_mismatch($sformatf("padding bits got %h", data[OUT_W-1:PAD_LSB]));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				regfile[i] <= (i == REG_MOVE_DURATION) ? DATA_W'(1) : '0;
			expected_points.delete();
			queued <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_point(m_tdata);
			if (s_tvalid && s_tready)
				expected_points.push_back(cubic_point(s_tdata));
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
				regfile[paddr[ADDR_W-1:2]] <= pwdata;
			queued <= expected_points.size();
		end
	end

endmodule

@@ test/cubic_point_to_point_interpolator_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the cubic point-to-point interpolator: drives time samples and APB
// register settings with random idling on both streams, and gives the verdict.
// Depends on cptpi_pkg, cubic_point_to_point_interpolator and trajectory_checker.
module cubic_point_to_point_interpolator_tb;
	import cptpi_pkg::*;

	localparam int LATENCY       = FRACTION_BITS_DEF + 5;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_PHASES = 17;
	localparam int PHASE_ITEMS   = 100;
	localparam int CALM_PHASES   = 2;
	localparam int PAUSE_PHASE   = 3;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int          mismatches;
	int          outstanding;
	int          points_checked;
	int          ticks_sent = 0;
	int          settings_used = 0;
	int          quiet_cycles = 0;
	int          stall_left = 0;
	logic        calm = 1'b0;
	logic [31:0] cur_start = '0;
	logic [31:0] cur_dur = 32'd1;

	cubic_point_to_point_interpolator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	trajectory_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.points_checked (points_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// output stalls in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 13);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("%t no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("cubic_point_to_point_interpolator_tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_setting(input logic [31:0] st, dur, sx, sy, sz, tx, ty, tz);
		write_reg(REG_START_TIME, st);
		write_reg(REG_MOVE_DURATION, dur);
		write_reg(REG_START_X, sx);
		write_reg(REG_START_Y, sy);
		write_reg(REG_START_Z, sz);
		write_reg(REG_TARGET_X, tx);
		write_reg(REG_TARGET_Y, ty);
		write_reg(REG_TARGET_Z, tz);
		cur_start = st;
		cur_dur = dur;
		settings_used++;
	endtask

	task automatic send_tick(input logic [31:0] t);
		int gap;
		gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
		s_tvalid <= 1'b1;
		s_tdata <= t;
		do @(posedge clk); while (s_tready !== 1'b1);
		ticks_sent++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic [31:0] pick_position();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return 32'($urandom_range(0, 2000)) - 32'd1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_start();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 5000));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_duration();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			3, 4: return 32'($urandom_range(2, 64));
			5: return 32'($urandom_range(65, 5000));
			6: return 32'($urandom_range(2, 1 << 20));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_tick();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return cur_start - 32'($urandom_range(1, 50));
			2: return cur_start + cur_dur + 32'($urandom_range(0, 3));
			3: return cur_start + cur_dur - 32'd1;
			default: return (cur_dur == 0) ? cur_start : cur_start + ($urandom % cur_dur);
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: start 0, duration 1
		send_tick(32'd0);
		send_tick(32'd1);
		send_tick(32'hFFFF_FFFF);
		drain();

		// full-scale swing, samples around both ends of the move
		load_setting(32'd1000, 32'd100, 32'h8000_0000, 32'h7FFF_FFFF, pick_position(),
			32'h7FFF_FFFF, 32'h8000_0000, pick_position());
		send_tick(32'd0);
		send_tick(32'd999);
		send_tick(32'd1000);
		send_tick(32'd1001);
		send_tick(32'd1050);
		send_tick(32'd1099);
		send_tick(32'd1100);
		send_tick(32'd1101);
		send_tick(32'hFFFF_FFFF);
		drain();

		// zero duration
		load_setting(32'd500, 32'd0, pick_position(), pick_position(), pick_position(),
			pick_position(), pick_position(), pick_position());
		send_tick(32'd499);
		send_tick(32'd500);
		send_tick(32'd501);
		drain();

		// longest move
		load_setting(32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		send_tick(32'h7FFF_FFFF);
		send_tick(32'hFFFF_FFFE);
		send_tick(32'hFFFF_FFFF);
		drain();

		// start at the top of the time axis
		load_setting(32'hFFFF_FFFF, 32'd10, pick_position(), pick_position(), pick_position(),
			pick_position(), pick_position(), pick_position());
		send_tick(32'hFFFF_FFFE);
		send_tick(32'hFFFF_FFFF);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			calm = (ph >= RANDOM_PHASES - CALM_PHASES);
			load_setting(pick_start(), pick_duration(), pick_position(), pick_position(),
				pick_position(), pick_position(), pick_position(), pick_position());
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == PAUSE_PHASE && k == PHASE_ITEMS / 2)
					drain();
				send_tick(pick_tick());
			end
		end
		drain();
		repeat (LATENCY + 4) @(posedge clk);

		$display("%0d time samples over %0d register settings, %0d results compared",
			ticks_sent, settings_used, points_checked);
		$display("samples fell before the start, inside the move and at or past its end");
		if (mismatches == 0 && outstanding == 0)
			$display("cubic_point_to_point_interpolator_tb: done, clean");
		else
			$display("cubic_point_to_point_interpolator_tb: done, errors");
		$finish;
	end

endmodule
